### rtl/mcc_pkg.sv
// Shared constants, register codes, state and command types for the mask filter.
`default_nettype none
package mcc_pkg;

    localparam int MASK_DIM     = 3;
    localparam int NCELL        = MASK_DIM * MASK_DIM;
    localparam int CELL_W       = $clog2(NCELL);
    localparam int MAX_LINE_DEF = 1024;

    localparam int PIX_W  = 8;
    localparam int COEF_W = 8;
    localparam int DIV_W  = 16;
    localparam int IMW_W  = 11;
    localparam int IMH_W  = 16;
    localparam int ACC_W  = 21;
    localparam int ABS_W  = 11;
    localparam int DVD_W  = 20;
    localparam int CNT_W  = $clog2(DVD_W);

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [7:0] PIX_MAX = 8'hFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CELL_ADDR,
        ST_CELL_READ,
        ST_CELL_MAC,
        ST_DIV_LOAD_A,
        ST_DIV_A,
        ST_DIV_LOAD_B,
        ST_DIV_B,
        ST_EMIT
    } mcc_state_t;

    typedef struct packed {
        logic step_in;
        logic win_start;
        logic cell_addr;
        logic cell_read;
        logic cell_mac;
        logic div_load_a;
        logic div_load_b;
        logic div_step;
        logic emit;
    } mcc_cmd_t;

    typedef struct packed {
        logic fire;
        logic cell_last;
        logic div_last;
        logic out_free;
    } mcc_status_t;

endpackage
`default_nettype wire

### rtl/mcc_if.sv
// Request channel interfaces: pixel input and filtered result output.
`default_nettype none
interface mcc_in_if
    import mcc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output cmd, output pixel, input ready);
    modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

interface mcc_out_if
    import mcc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] result_pixel;
    logic             last;

    modport source (output valid, output result_pixel, output last, input ready);
    modport sink   (input valid, input result_pixel, input last, output ready);
endinterface
`default_nettype wire

### rtl/mcc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2052
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/mcc_ctrl.sv
// Sequencer for the mask filter: accept, window walk, two divisions, emit.
`default_nettype none
module mcc_ctrl
    import mcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire mcc_status_t status,
    output logic             in_ready,
    output mcc_cmd_t         cmd
);

    mcc_state_t state_reg;
    mcc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:      state_next = status.fire ? ST_CELL_ADDR : ST_IDLE;
            ST_CELL_ADDR:  state_next = ST_CELL_READ;
            ST_CELL_READ:  state_next = ST_CELL_MAC;
            ST_CELL_MAC:   state_next = status.cell_last ? ST_DIV_LOAD_A : ST_CELL_ADDR;
            ST_DIV_LOAD_A: state_next = ST_DIV_A;
            ST_DIV_A:      state_next = status.div_last ? ST_DIV_LOAD_B : ST_DIV_A;
            ST_DIV_LOAD_B: state_next = ST_DIV_B;
            ST_DIV_B:      state_next = status.div_last ? ST_EMIT : ST_DIV_B;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.step_in = in_valid;
            end
            ST_CHECK:      cmd.win_start  = status.fire;
            ST_CELL_ADDR:  cmd.cell_addr  = 1'b1;
            ST_CELL_READ:  cmd.cell_read  = 1'b1;
            ST_CELL_MAC:   cmd.cell_mac   = 1'b1;
            ST_DIV_LOAD_A: cmd.div_load_a = 1'b1;
            ST_DIV_A:      cmd.div_step   = 1'b1;
            ST_DIV_LOAD_B: cmd.div_load_b = 1'b1;
            ST_DIV_B:      cmd.div_step   = 1'b1;
            ST_EMIT:       cmd.emit       = status.out_free;
            default:       cmd            = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/mcc_datapath.sv
// Datapath: config registers, positions, pixel history, MAC and shared divider.
`default_nettype none
module mcc_datapath
    import mcc_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_cmd,
    input  wire logic [PIX_W-1:0]     in_pixel,
    input  wire mcc_cmd_t             cmd,
    output mcc_status_t               status,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [PIX_W-1:0]          out_result,
    output logic                      out_last
);

    localparam int HIST_LEN = 2 * MAX_LINE + 4;
    localparam int AW       = $clog2(HIST_LEN);
    localparam int OFF_W    = AW + 1;
    localparam int COL_W    = $clog2(MAX_LINE);
    localparam int W_W      = $clog2(MAX_LINE + 1);
    localparam int LAG_W    = $clog2(MAX_LINE + 3);
    localparam int CMP_W    = W_W + 2;

    // configuration
    logic [CFG_W-1:0]  coef_low_reg;
    logic [COEF_W-1:0] coef_high_reg;
    logic [DIV_W-1:0]  divisor_reg;
    logic              mode_reg;
    logic [IMW_W-1:0]  image_width_reg;
    logic [IMH_W-1:0]  image_height_reg;

    // positions
    logic [COL_W-1:0] in_col_reg;
    logic [IMH_W-1:0] in_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [IMH_W-1:0] out_row_reg;
    logic [LAG_W-1:0] lag_reg;
    logic [AW-1:0]    wr_ptr_reg;

    // window walk
    logic [CELL_W-1:0] cell_reg;
    logic [1:0]        crow_reg;
    logic [1:0]        ccol_reg;
    logic [CELL_W-1:0] ci_reg;
    logic              inside_reg;
    logic [OFF_W-1:0]  off_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [ABS_W-1:0]  abs_reg;

    // divider
    logic [DVD_W-1:0] dvd_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [PIX_W-1:0] out_result_reg;
    logic             out_last_reg;
    logic             out_valid_reg;

    logic [W_W-1:0]   eff_w;
    logic [IMH_W-1:0] eff_h;
    logic             pix_write;
    logic [W_W-1:0]   in_col_inc;
    logic [W_W-1:0]   out_col_inc;
    logic             last_pos;
    logic             restart;
    logic [OFF_W-1:0] row_term;
    logic [OFF_W-1:0] col_term;
    logic [OFF_W-1:0] wr_ext;
    logic [AW-1:0]    rd_addr;
    logic [PIX_W-1:0] rd_data;
    logic signed [COEF_W-1:0] coef_s;
    logic signed [PIX_W:0]    pix_s;
    logic signed [COEF_W+PIX_W:0] prod;
    logic [COEF_W:0]  coef_abs;
    logic [DIV_W:0]   rem_sh;
    logic             rem_ge;
    logic             inside_next;

    // effective geometry
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_w = W_W'(1);
        end
        else if (32'(image_width_reg) > 32'(MAX_LINE))
        begin
            eff_w = W_W'(MAX_LINE);
        end
        else
        begin
            eff_w = W_W'(image_width_reg);
        end
        eff_h = (image_height_reg == '0) ? IMH_W'(1) : image_height_reg;
    end

    assign pix_write   = cmd.step_in && (in_cmd == CMD_PIXEL) && (in_row_reg < eff_h);
    assign in_col_inc  = W_W'(in_col_reg) + W_W'(1);
    assign out_col_inc = W_W'(out_col_reg) + W_W'(1);
    assign last_pos    = (out_row_reg == eff_h - IMH_W'(1)) && (out_col_inc == eff_w);
    assign restart     = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                                    (cfg_index == REG_IMAGE_HEIGHT));

    assign status.fire      = (in_row_reg >= eff_h) ||
                              (CMP_W'(lag_reg) >= CMP_W'(eff_w) + CMP_W'(2));
    assign status.cell_last = (cell_reg == CELL_W'(NCELL - 1));
    assign status.div_last  = (cnt_reg == CNT_W'(DVD_W - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    // cell geometry: skip cells that fall outside the image
    always_comb
    begin
        inside_next = 1'b1;
        if (crow_reg == 2'd0 && out_row_reg == '0)
        begin
            inside_next = 1'b0;
        end
        if (crow_reg == 2'd2 && out_row_reg == eff_h - IMH_W'(1))
        begin
            inside_next = 1'b0;
        end
        if (ccol_reg == 2'd0 && out_col_reg == '0)
        begin
            inside_next = 1'b0;
        end
        if (ccol_reg == 2'd2 && out_col_inc == eff_w)
        begin
            inside_next = 1'b0;
        end
        case (crow_reg)
            2'd0:    row_term = OFF_W'(eff_w);
            2'd2:    row_term = OFF_W'(0) - OFF_W'(eff_w);
            default: row_term = '0;
        endcase
        case (ccol_reg)
            2'd0:    col_term = OFF_W'(1);
            2'd2:    col_term = {OFF_W{1'b1}};
            default: col_term = '0;
        endcase
    end

    // history address: newest entry sits just below the write pointer
    assign wr_ext  = OFF_W'(wr_ptr_reg);
    assign rd_addr = (off_reg > wr_ext) ? AW'(wr_ext + OFF_W'(HIST_LEN) - off_reg)
                                        : AW'(wr_ext - off_reg);

    assign coef_s   = (ci_reg == CELL_W'(NCELL - 1)) ? coef_high_reg
                                                     : coef_low_reg[{ci_reg[2:0], 3'b000} +: 8];
    assign pix_s    = $signed({1'b0, rd_data});
    assign prod     = coef_s * pix_s;
    assign coef_abs = coef_s[COEF_W-1] ? ((COEF_W+1)'(0) - {coef_s[COEF_W-1], coef_s})
                                       : {1'b0, coef_s};

    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, den_reg};

    mcc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (HIST_LEN)
    ) u_line_store (
        .clk   (clk),
        .we    (pix_write),
        .waddr (wr_ptr_reg),
        .wdata (in_pixel),
        .re    (cmd.cell_read),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // configuration and position control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_low_reg     <= '0;
            coef_high_reg    <= '0;
            divisor_reg      <= DIV_W'(1);
            mode_reg         <= 1'b0;
            image_width_reg  <= IMW_W'(1024);
            image_height_reg <= IMH_W'(768);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            lag_reg          <= '0;
            wr_ptr_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COEF_LOW:     coef_low_reg     <= cfg_data;
                    REG_COEF_HIGH:    coef_high_reg    <= cfg_data[COEF_W-1:0];
                    REG_DIVISOR:      divisor_reg      <= cfg_data[DIV_W-1:0];
                    REG_MODE:         mode_reg         <= cfg_data[0];
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMW_W-1:0];
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMH_W-1:0];
                    default:          ;
                endcase
            end

            if (restart || (cmd.emit && last_pos))
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                lag_reg     <= '0;
            end
            else if (pix_write)
            begin
                lag_reg <= lag_reg + LAG_W'(1);
                if (in_col_inc >= eff_w)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + IMH_W'(1);
                end
                else
                begin
                    in_col_reg <= COL_W'(in_col_inc);
                end
            end
            else if (cmd.emit)
            begin
                lag_reg <= lag_reg - LAG_W'(1);
                if (out_col_inc >= eff_w)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + IMH_W'(1);
                end
                else
                begin
                    out_col_reg <= COL_W'(out_col_inc);
                end
            end

            if (pix_write)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(HIST_LEN - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // window accumulation and divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
            crow_reg <= '0;
            ccol_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.win_start)
            begin
                cell_reg <= '0;
                crow_reg <= '0;
                ccol_reg <= '0;
            end
            else if (cmd.cell_mac)
            begin
                cell_reg <= cell_reg + CELL_W'(1);
                if (ccol_reg == 2'd2)
                begin
                    ccol_reg <= '0;
                    crow_reg <= crow_reg + 2'd1;
                end
                else
                begin
                    ccol_reg <= ccol_reg + 2'd1;
                end
            end
            if (cmd.div_load_a || cmd.div_load_b)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.win_start)
        begin
            acc_reg <= '0;
            abs_reg <= '0;
        end
        if (cmd.cell_addr)
        begin
            inside_reg <= inside_next;
            off_reg    <= OFF_W'(lag_reg) + row_term + col_term;
            ci_reg     <= mode_reg ? cell_reg : CELL_W'(NCELL - 1) - cell_reg;
        end
        if (cmd.cell_mac && inside_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod);
            abs_reg <= abs_reg + ABS_W'(coef_abs);
        end
        if (cmd.div_load_a)
        begin
            // a negative sum ends at zero after clamping
            dvd_reg <= (!acc_reg[ACC_W-1]) ? acc_reg[DVD_W-1:0] : '0;
            den_reg <= (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_load_b)
        begin
            den_reg <= (abs_reg == '0) ? DIV_W'(1) : DIV_W'(abs_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? DIV_W'(rem_sh - {1'b0, den_reg}) : DIV_W'(rem_sh);
            dvd_reg <= {dvd_reg[DVD_W-2:0], rem_ge};
        end
        if (cmd.emit)
        begin
            out_result_reg <= (dvd_reg > DVD_W'(PIX_MAX)) ? PIX_MAX : dvd_reg[PIX_W-1:0];
            out_last_reg   <= last_pos;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_last   = out_last_reg;

endmodule
`default_nettype wire

### rtl/mask_convolve_correlate.sv
// Top level of the streaming 3x3 mask filter (convolution / correlation).
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    cmd (0 pixel, 1 drain), pixel[7:0]
//  out_ch    out  valid / ready    result_pixel[7:0], last
//  cfg       in   cfg_we           cfg_index[2:0], cfg_data[63:0]
//
// A request that yields no result passes through accept and check only;
// one that completes a window also walks the nine cells (address, single
// read port of the history RAM, multiply-accumulate), makes two passes
// through the shared 20-step radix-2 divider, then emits.
// Reset clears all positions and loads the register defaults; the history
// RAM is not cleared and its data is only used where this frame wrote it.
// A result waiting in the output register does not block the next input
// request; a stalled output only holds the block in its emit step.
`default_nettype none
module mask_convolve_correlate
    import mcc_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    mcc_in_if.sink                    in_ch,
    mcc_out_if.source                 out_ch
);

    mcc_cmd_t    cmd;
    mcc_status_t status;

    // sequencer: owns the input handshake and the step order
    mcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .status   (status),
        .in_ready (in_ch.ready),
        .cmd      (cmd)
    );

    // datapath: registers, pixel history, arithmetic and output register
    mcc_datapath #(
        .MAX_LINE (MAX_LINE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_cmd     (in_ch.cmd),
        .in_pixel   (in_ch.pixel),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_result (out_ch.result_pixel),
        .out_last   (out_ch.last)
    );

endmodule
`default_nettype wire

### rtl/mcc_checker.sv
// Port-level checks for the mask filter, bound to the top level.
`default_nettype none
module mcc_checker
    import mcc_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [PIX_W-1:0] result_pixel,
    input wire logic             last
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result_pixel) && $stable(last))
        else $error("stalled result changed");

    // one request at a time: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted back to back");

    // a new result appears only out of the emit step, never while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without processing");

endmodule

bind mask_convolve_correlate mcc_checker u_mcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .result_pixel (out_ch.result_pixel),
    .last         (out_ch.last)
);
`default_nettype wire

### sim/mcc_checker.sv
// Checker for the mask filter: predicts each filtered pixel and compares the output stream.
module mcc_scoreboard
    import mcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    mcc_in_if                    in_ch,
    mcc_out_if                   out_ch,
    output int                   mismatches,
    output int                   pending,
    output int                   results_seen
);

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
    } filt_res_t;

    filt_res_t          filt_q[$];
    logic [PIX_W-1:0]   frame_px[int];

    logic [63:0]        coef_lo;
    logic [7:0]         coef_hi;
    logic [DIV_W-1:0]   div_r;
    logic               corr_mode;
    logic [IMW_W-1:0]   width_r;
    logic [IMH_W-1:0]   height_r;
    int                 in_col, in_row, out_col, out_row;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int coef_of(input int ci);
        logic signed [7:0] c;
        c = (ci < 8) ? coef_lo[8*ci +: 8] : coef_hi;
        return int'(c);
    endfunction

    task automatic restart_positions();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    // Take one request, store its pixel, emit the next filtered pixel once its window is full.
    task automatic filter_step(input logic cmd, input logic [PIX_W-1:0] pix);
        int w, h, total, n, k, need, sum, abs_sum, rr, cc, ci, cv, dv;
        filt_res_t r;
        w = (width_r == 0) ? 1 : (width_r > MAX_LINE_DEF) ? MAX_LINE_DEF : int'(width_r);
        h = (height_r == 0) ? 1 : int'(height_r);
        total = w * h;
        if (cmd == CMD_PIXEL && in_row < h) begin
            frame_px[in_row * w + in_col] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        n = in_row * w + in_col;
        if (out_row >= h)
            return;
        k = out_row * w + out_col;
        need = k + w + 2;
        if (need > total)
            need = total;
        if (n < need || n == 0)
            return;
        sum = 0;
        abs_sum = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = out_row + dr;
                cc = out_col + dc;
                if (rr >= 0 && cc >= 0 && rr < h && cc < w) begin
                    ci = corr_mode ? (dr + 1) * 3 + (dc + 1) : (1 - dr) * 3 + (1 - dc);
                    cv = coef_of(ci);
                    sum += cv * int'(frame_px[rr * w + cc]);
                    abs_sum += (cv < 0) ? -cv : cv;
                end
            end
        end
        dv = (div_r == 0) ? 1 : int'(div_r);
        sum = sum / dv;
        sum = sum / ((abs_sum != 0) ? abs_sum : 1);
        if (sum > 255)
            sum = 255;
        if (sum < 0)
            sum = 0;
        r.pix = sum[PIX_W-1:0];
        r.last = (k == total - 1);
        filt_q.push_back(r);
        if (r.last) begin
            restart_positions();
        end
        else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        filt_res_t want;
        if (!rst_n) begin
            coef_lo = '0;
            coef_hi = '0;
            div_r = 1;
            corr_mode = 1'b0;
            width_r = 1024;
            height_r = 768;
            restart_positions();
            filt_q.delete();
            mismatches = 0;
            results_seen = 0;
            pending <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_COEF_LOW:     coef_lo = cfg_data;
                    REG_COEF_HIGH:    coef_hi = cfg_data[7:0];
                    REG_DIVISOR:      div_r = cfg_data[DIV_W-1:0];
                    REG_MODE:         corr_mode = cfg_data[0];
                    REG_IMAGE_WIDTH:
                    begin
                        width_r = cfg_data[IMW_W-1:0];
                        restart_positions();
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_r = cfg_data[IMH_W-1:0];
                        restart_positions();
                    end
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (filt_q.size() == 0) begin
                    report_mismatch("unexpected result_pixel", out_ch.result_pixel, -1);
                end
                else begin
                    want = filt_q.pop_front();
                    if (out_ch.result_pixel !== want.pix)
                        report_mismatch("result_pixel", out_ch.result_pixel, want.pix);
                    if (out_ch.last !== want.last)
                        report_mismatch("last", out_ch.last, want.last);
                end
            end
            if (in_ch.valid && in_ch.ready)
                filter_step(in_ch.cmd, in_ch.pixel);
            pending <= filt_q.size();
        end
    end

endmodule

### sim/tb_mask_convolve_correlate.sv
// Testbench top for the mask filter: clock, reset, stimulus, output back-pressure and verdict.
module tb_mask_convolve_correlate;
    import mcc_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int pending;
    int results_seen;

    // Idling controls for the sender and the receiver.
    logic quiet;        // no idling at all
    logic long_hold;    // receiver holds off for a long stretch
    int   requests_sent;
    int   frames_run;

    mcc_in_if  in_ch ();
    mcc_out_if out_ch ();

    mask_convolve_correlate DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    mcc_scoreboard checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(4 * 4_000_000);
        $display("Timeout waiting for filtered pixels");
        $display("Mismatches found");
        $finish;
    end

    // Receiver: drop ready in random bursts, or for one long stretch when asked.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (500) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Write one register; hold the enable for exactly one edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Wait until every expected result is out, then let the block finish its last request.
    task automatic settle();
        do @(posedge clk); while (pending != 0);
        repeat (80) @(posedge clk);
    endtask

    // Offer one request, optionally after a random idle burst, and hold it until accepted.
    task automatic send_req(input logic cmd, input logic [PIX_W-1:0] pix);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= cmd;
        in_ch.pixel <= pix;
        do @(posedge clk); while (!in_ch.ready);
        requests_sent++;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return PIX_MAX;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Results still owed once every pixel of a w x h frame has gone in.
    function automatic int drains_owed(input int w, input int h);
        int total, emitted, need;
        total = w * h;
        emitted = 0;
        for (int n = 1; n <= total; n++) begin
            need = emitted + w + 2;
            if (need > total)
                need = total;
            if (n >= need)
                emitted++;
        end
        return total - emitted;
    endfunction

    // Feed one whole frame, with stray drain beats inside it, then flush the tail.
    // Part of the flush uses pixel beats, which the block must treat as drains.
    task automatic run_frame(input int w, input int h, input int noise_pct);
        int owed;
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_req(CMD_DRAIN, PIX_W'($urandom));
            send_req(CMD_PIXEL, pick_pixel());
        end
        owed = drains_owed(w, h);
        for (int i = 0; i < owed; i++)
            send_req($urandom_range(0, 3) == 0 ? CMD_PIXEL : CMD_DRAIN, PIX_W'($urandom));
        in_ch.valid <= 1'b0;
        frames_run++;
        settle();
    endtask

    // Load a random mask, divisor and mode; the extremes come up now and then.
    task automatic random_mask();
        logic [63:0] lo;
        lo = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: lo = 64'h8080_8080_8080_8080;
            1: lo = 64'h7F7F_7F7F_7F7F_7F7F;
            2: lo = '0;
            default: ;
        endcase
        write_reg(REG_COEF_LOW, lo);
        write_reg(REG_COEF_HIGH, 64'($urandom_range(0, 255)));
        case ($urandom_range(0, 7))
            0:       write_reg(REG_DIVISOR, 64'd0);
            1:       write_reg(REG_DIVISOR, 64'd65535);
            default: write_reg(REG_DIVISOR, 64'($urandom_range(1, 3)));
        endcase
        write_reg(REG_MODE, 64'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int w, h;
        rst_n       = 1'b0;
        quiet       = 1'b0;
        long_hold   = 1'b0;
        requests_sent = 0;
        frames_run  = 0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_ch.valid <= 1'b0;
        in_ch.cmd   <= CMD_PIXEL;
        in_ch.pixel <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: zero width and zero height both act as one; zero divisor acts as one.
        write_reg(REG_COEF_LOW, 64'h0000_0000_7F00_0000);
        write_reg(REG_COEF_HIGH, 64'h80);
        write_reg(REG_DIVISOR, 64'd0);
        write_reg(REG_MODE, 64'd0);
        write_reg(REG_IMAGE_WIDTH, 64'd0);
        write_reg(REG_IMAGE_HEIGHT, 64'd0);
        send_req(CMD_DRAIN, 8'hA5);     // early drain: nothing to emit
        send_req(CMD_PIXEL, PIX_MAX);
        in_ch.valid <= 1'b0;
        settle();

        // Directed: extreme coefficients, convolve on a 3x3 frame, then correlate on a 2x3 frame.
        write_reg(REG_COEF_LOW, 64'h7F80_7F80_7F80_7F80);
        write_reg(REG_COEF_HIGH, 64'h7F);
        write_reg(REG_DIVISOR, 64'd1);
        write_reg(REG_IMAGE_WIDTH, 64'd3);
        write_reg(REG_IMAGE_HEIGHT, 64'd3);
        run_frame(3, 3, 10);
        write_reg(REG_MODE, 64'd1);
        // Restart mid-frame: two pixels in, then rewrite the geometry.
        send_req(CMD_PIXEL, 8'h00);
        send_req(CMD_PIXEL, PIX_MAX);
        in_ch.valid <= 1'b0;
        settle();
        write_reg(REG_IMAGE_WIDTH, 64'd2);
        run_frame(2, 3, 0);

        // Random frames: small geometries, some with no idling.
        while (requests_sent < 1050) begin
            random_mask();
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0)
                w = 1;
            write_reg(REG_IMAGE_WIDTH, 64'(w));
            write_reg(REG_IMAGE_HEIGHT, 64'(h));
            quiet = ($urandom_range(0, 4) == 0);
            if (frames_run == 20)
                long_hold = 1'b1;   // let the block back up and stall its input
            run_frame(w, h, 8);
        end

        // Last part: no idling on either side.
        quiet = 1'b1;
        for (int i = 0; i < 4; i++) begin
            random_mask();
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 4);
            write_reg(REG_IMAGE_WIDTH, 64'(w));
            write_reg(REG_IMAGE_HEIGHT, 64'(h));
            run_frame(w, h, 5);
        end

        $display("Sent %0d requests over %0d frames, %0d filtered pixels checked",
                 requests_sent, frames_run, results_seen);
        $display("Covered both modes, clamped geometry, zero divisor and extreme masks");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
